### src/itab_pkg.sv
// Shared types, constants and digit table for the integer to ASCII converter.
`default_nettype none
package itab_pkg;

   localparam int VALUE_BITS_DEF     = 32;
   localparam int DIV_BITS_PER_CYCLE = 8;
   localparam int FIFO_DEPTH         = 2;

   localparam logic [7:0] RADIX_MIN    = 8'd2;
   localparam logic [7:0] RADIX_MAX    = 8'd16;
   localparam logic [7:0] SIGNED_RADIX = 8'd10;
   localparam logic [7:0] ASCII_MINUS  = 8'h2D;
   localparam logic [7:0] ASCII_NONE   = 8'h00;

   localparam logic [7:0] DIGIT_TABLE [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   typedef struct packed {
      logic       err;
      logic       neg;
      logic [4:0] radix;
   } itab_cls_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_SIGN,
      BACK_EMIT
   } itab_back_state_type;

endpackage
`default_nettype wire

### src/itab_front.sv
// Front end: accepts request words, checks the radix and forms the magnitude.
`default_nettype none
module itab_front #(
   parameter int VALUE_BITS = itab_pkg::VALUE_BITS_DEF
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic [7:0]                   req_radix,
   input  logic                         fifo_full,
   output logic                         push,
   output itab_pkg::itab_cls_type       cls,
   output logic [VALUE_BITS-1:0]        mag
);
   import itab_pkg::*;

   logic [VALUE_BITS-1:0] raw;
   logic                  bad;
   logic                  neg;

   always_comb begin
      raw = req_value;
      bad = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
      neg = !bad && (req_radix == SIGNED_RADIX) && raw[VALUE_BITS-1];
      mag = neg ? (~raw + 1'b1) : raw;
      cls.err   = bad;
      cls.neg   = neg;
      cls.radix = req_radix[4:0];
   end

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

endmodule
`default_nettype wire

### src/itab_fifo.sv
// Short queue of classified words between front and back.
`default_nettype none
module itab_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data,
   input  logic             rd_pop
);
   import itab_pkg::*;

   localparam int PTRW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNTW = $clog2(FIFO_DEPTH + 1);

   logic [WIDTH-1:0] mem [FIFO_DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign full     = (count_ff == CNTW'(FIFO_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

### src/itab_div.sv
// Iterative divider by a small radix, several quotient bits per cycle.
`default_nettype none
module itab_div #(
   parameter int VALUE_BITS = itab_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [4:0]            radix,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [3:0]            remainder
);
   import itab_pkg::*;

   localparam int NCYC = (VALUE_BITS + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
   localparam int PAD  = NCYC * DIV_BITS_PER_CYCLE;
   localparam int CW   = $clog2(NCYC + 1);

   logic [PAD-1:0] work_ff, work_in;
   logic [3:0]     rem_ff, rem_in;
   logic [4:0]     radix_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;

   always_comb begin
      logic [4:0] t;
      t       = '0;
      work_in = work_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         t       = {rem_in, work_in[PAD-1]};
         work_in = {work_in[PAD-2:0], 1'b0};
         if (t >= radix_ff) begin
            t          = t - radix_ff;
            work_in[0] = 1'b1;
         end
         rem_in = t[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NCYC);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff  <= PAD'(dividend);
         rem_ff   <= '0;
         radix_ff <= radix;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = work_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule
`default_nettype wire

### src/itab_back.sv
// Back end: divides out the digits, stacks them and emits them most significant first.
`default_nettype none
module itab_back #(
   parameter int VALUE_BITS = itab_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  itab_pkg::itab_cls_type q_cls,
   input  logic [VALUE_BITS-1:0]  q_mag,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last,
   output logic                   rsp_error
);
   import itab_pkg::*;

   localparam int CNTW = $clog2(VALUE_BITS + 1);

   itab_back_state_type   state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [4:0]            radix_ff, radix_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  err_ff, err_in;
   logic [3:0]            stack_ff [VALUE_BITS];

   logic                  out_free;
   logic                  push;
   logic                  pop;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [4:0]            div_radix;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [3:0]            div_remainder;

   itab_div #(.VALUE_BITS(VALUE_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      radix_in     = radix_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      q_pop        = 1'b0;
      push         = 1'b0;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      div_radix    = radix_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         BACK_IDLE: begin
            div_radix    = q_cls.radix;
            div_dividend = q_mag;
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_cls.err) begin
                  rsp_valid_in = 1'b1;
                  char_in      = ASCII_NONE;
                  last_in      = 1'b1;
                  err_in       = 1'b1;
               end else begin
                  neg_in    = q_cls.neg;
                  radix_in  = q_cls.radix;
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = BACK_DIVIDE;
               end
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               push     = 1'b1;
               count_in = count_ff + 1'b1;
               if (div_quotient == '0) begin
                  state_in = neg_ff ? BACK_SIGN : BACK_EMIT;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         BACK_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = ASCII_MINUS;
               last_in      = 1'b0;
               err_in       = 1'b0;
               state_in     = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = DIGIT_TABLE[stack_ff[0]];
               last_in      = (count_ff == CNTW'(1));
               err_in       = 1'b0;
               pop          = 1'b1;
               count_in     = count_ff - 1'b1;
               if (count_ff == CNTW'(1)) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[0] <= div_remainder;
         for (int i = 1; i < VALUE_BITS; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < VALUE_BITS - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_error     = err_ff;

endmodule
`default_nettype wire

### src/integer_to_ascii_any_base_top.sv
// Top level of the integer to ASCII converter, radix 2 to 16.
// Request channel (req_valid/req_stall): one word carries req_value, a
// VALUE_BITS-bit two's complement number, and req_radix. A word is taken at a
// clock edge with req_valid high and req_stall low.
// Response channel (rsp_valid/rsp_stall): one word per ASCII character, most
// significant digit first; rsp_last marks the final character. Radix 10 prints
// a leading '-' for negative values; other radixes print the unsigned pattern.
// A radix outside 2..16 yields a single word with rsp_error and rsp_last set
// and rsp_character zero.
// Each digit takes one pass of the iterative divider, which retires 8
// quotient bits per cycle. After the last digit each character leaves at one
// per cycle while rsp_stall is low. The back end returns to idle when the last
// character is loaded and only then takes the next queued word, so it does
// not start a conversion before the last one is through; bad-radix words go
// at one per cycle while rsp_stall is low. The front and a two-word queue
// keep taking requests meanwhile. rsp_stall holds the output register; the
// divider runs on and the back end waits at its next character, so the queue
// fills and req_stall rises. Synchronous reset empties the queue, drops any
// conversion in progress and clears rsp_valid.
`default_nettype none
module integer_to_ascii_any_base_top #(
   parameter int VALUE_BITS = itab_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic [7:0]                   req_radix,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last,
   output logic                         rsp_error
);
   import itab_pkg::*;

   localparam int CLSW = $bits(itab_cls_type);
   localparam int QW   = CLSW + VALUE_BITS;

   logic                  fifo_full;
   logic                  push;
   itab_cls_type          front_cls;
   logic [VALUE_BITS-1:0] front_mag;
   logic                  q_valid;
   logic [QW-1:0]         q_data;
   logic                  q_pop;
   itab_cls_type          q_cls;
   logic [VALUE_BITS-1:0] q_mag;

   itab_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .req_radix (req_radix),
      .fifo_full (fifo_full),
      .push      (push),
      .cls       (front_cls),
      .mag       (front_mag)
   );

   itab_fifo #(.WIDTH(QW)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push),
      .wr_data  ({front_cls, front_mag}),
      .full     (fifo_full),
      .rd_valid (q_valid),
      .rd_data  (q_data),
      .rd_pop   (q_pop)
   );

   assign q_cls = itab_cls_type'(q_data[VALUE_BITS +: CLSW]);
   assign q_mag = q_data[VALUE_BITS-1:0];

   itab_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cls         (q_cls),
      .q_mag         (q_mag),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_error     (rsp_error)
   );

endmodule
`default_nettype wire
